// File: hdl/jtok_pkg.sv
`default_nettype none

package jtok_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;

    typedef enum logic [3:0] {
        KIND_BEGIN_OBJ = 4'd0,
        KIND_END_OBJ   = 4'd1,
        KIND_BEGIN_ARR = 4'd2,
        KIND_END_ARR   = 4'd3,
        KIND_COLON     = 4'd4,
        KIND_COMMA     = 4'd5,
        KIND_TRUE      = 4'd6,
        KIND_FALSE     = 4'd7,
        KIND_NULL      = 4'd8,
        KIND_STRING    = 4'd9,
        KIND_NUMBER    = 4'd10,
        KIND_EOF       = 4'd11,
        KIND_ERROR     = 4'd12
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_BAD_LITERAL = 2'd1,
        ERR_NO_QUOTE    = 2'd2,
        ERR_BAD_CHAR    = 2'd3
    } err_code_t;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_LIT,
        MODE_STR,
        MODE_ESC,
        MODE_HEX,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_ERR
    } mode_t;

    typedef enum logic [1:0] {
        LIT_TRUE  = 2'd0,
        LIT_FALSE = 2'd1,
        LIT_NULL  = 2'd2
    } lit_sel_t;

    typedef struct packed {
        kind_t     kind;
        err_code_t code;
    } rec_ctl_t;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_U         = 8'h75;

    // Expected letter of a literal's tail ("rue", "alse", "ull").
    function automatic logic [7:0] lit_char(input lit_sel_t sel, input logic [1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (sel)
            LIT_TRUE:
            begin
                case (idx)
                    2'd0:    ch = 8'h72;
                    2'd1:    ch = 8'h75;
                    default: ch = 8'h65;
                endcase
            end
            LIT_FALSE:
            begin
                case (idx)
                    2'd0:    ch = 8'h61;
                    2'd1:    ch = 8'h6C;
                    2'd2:    ch = 8'h73;
                    default: ch = 8'h65;
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    ch = 8'h75;
                    default: ch = 8'h6C;
                endcase
            end
        endcase
        return ch;
    endfunction

    // Index of the final letter of a literal's tail.
    function automatic logic [1:0] lit_final(input lit_sel_t sel);
        return (sel == LIT_FALSE) ? 2'd3 : 2'd2;
    endfunction

    function automatic kind_t lit_kind(input lit_sel_t sel);
        kind_t k;
        unique case (sel)
            LIT_TRUE:  k = KIND_TRUE;
            LIT_FALSE: k = KIND_FALSE;
            default:   k = KIND_NULL;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hdl/jtok_if.sv
`default_nettype none

interface jtok_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_text;

    modport source (output valid, text_char, end_of_text, input ready);
    modport sink   (input valid, text_char, end_of_text, output ready);
endinterface

interface jtok_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic [1:0]  error_code;
    logic        last_of_run;

    modport source (output valid, token_kind, token_start, token_length, error_code,
                    last_of_run, input ready);
    modport sink   (input valid, token_kind, token_start, token_length, error_code,
                    last_of_run, output ready);
endinterface

`default_nettype wire

// File: hdl/jtok_lexer.sv
`default_nettype none

module jtok_lexer #(
    parameter int POSITION_BITS = jtok_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     advance,
    input  wire logic [7:0]               ch,
    input  wire logic                     last,
    output logic [1:0]                    rec_cnt,
    output jtok_pkg::rec_ctl_t            rec_ctl   [3],
    output logic [POSITION_BITS-1:0]      rec_start [3],
    output logic [POSITION_BITS-1:0]      rec_len   [3]
);

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    jtok_pkg::mode_t                mode_reg,  mode_next;
    jtok_pkg::lit_sel_t             which_reg, which_next;
    logic [1:0]                     idx_reg,   idx_next;
    logic [2:0]                     hex_reg,   hex_next;
    logic [POSITION_BITS-1:0]       pos_reg,   pos_next;
    logic [POSITION_BITS-1:0]       tb_reg,    tb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= jtok_pkg::MODE_IDLE;
            which_reg <= jtok_pkg::LIT_TRUE;
            idx_reg   <= '0;
            hex_reg   <= '0;
            pos_reg   <= '0;
            tb_reg    <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            which_reg <= which_next;
            idx_reg   <= idx_next;
            hex_reg   <= hex_next;
            pos_reg   <= pos_next;
            tb_reg    <= tb_next;
        end
    end

    always_comb
    begin
        logic [POSITION_BITS-1:0] nxt;
        logic [POSITION_BITS-1:0] dot;
        logic                     fresh;
        logic                     digit;
        logic                     errored;
        logic [1:0]               n;

        nxt     = pos_reg + POS_ONE;
        dot     = pos_reg - POS_ONE;
        fresh   = 1'b0;
        errored = 1'b0;
        digit   = (ch >= jtok_pkg::CH_0) && (ch <= jtok_pkg::CH_9);
        n       = 2'd0;

        mode_next  = mode_reg;
        which_next = which_reg;
        idx_next   = idx_reg;
        hex_next   = hex_reg;
        tb_next    = tb_reg;

        for (int k = 0; k < 3; k++)
        begin
            rec_ctl[k]   = '{kind: jtok_pkg::KIND_BEGIN_OBJ, code: jtok_pkg::ERR_NONE};
            rec_start[k] = '0;
            rec_len[k]   = '0;
        end

        // Advance the token in progress.
        unique case (mode_reg)
            jtok_pkg::MODE_IDLE:
            begin
                fresh = 1'b1;
            end
            jtok_pkg::MODE_LIT:
            begin
                if (ch == jtok_pkg::lit_char(which_reg, idx_reg))
                begin
                    if (idx_reg == jtok_pkg::lit_final(which_reg))
                    begin
                        rec_ctl[n]   = '{kind: jtok_pkg::lit_kind(which_reg),
                                         code: jtok_pkg::ERR_NONE};
                        rec_start[n] = tb_reg;
                        rec_len[n]   = nxt - tb_reg;
                        n            = n + 2'd1;
                        mode_next    = jtok_pkg::MODE_IDLE;
                        idx_next     = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                else
                begin
                    rec_ctl[n]   = '{kind: jtok_pkg::KIND_ERROR, code: jtok_pkg::ERR_BAD_LITERAL};
                    rec_start[n] = tb_reg;
                    rec_len[n]   = nxt - tb_reg;
                    n            = n + 2'd1;
                    mode_next    = jtok_pkg::MODE_ERR;
                end
            end
            jtok_pkg::MODE_STR:
            begin
                if (ch == jtok_pkg::CH_QUOTE)
                begin
                    rec_ctl[n]   = '{kind: jtok_pkg::KIND_STRING, code: jtok_pkg::ERR_NONE};
                    rec_start[n] = tb_reg;
                    rec_len[n]   = nxt - tb_reg;
                    n            = n + 2'd1;
                    mode_next    = jtok_pkg::MODE_IDLE;
                end
                else if (ch == jtok_pkg::CH_BACKSLASH)
                begin
                    mode_next = jtok_pkg::MODE_ESC;
                end
            end
            jtok_pkg::MODE_ESC:
            begin
                if (ch == jtok_pkg::CH_U)
                begin
                    hex_next  = 3'd4;
                    mode_next = jtok_pkg::MODE_HEX;
                end
                else
                begin
                    mode_next = jtok_pkg::MODE_STR;
                end
            end
            jtok_pkg::MODE_HEX:
            begin
                hex_next = hex_reg - 3'd1;
                if (hex_reg == 3'd1)
                begin
                    mode_next = jtok_pkg::MODE_STR;
                end
            end
            jtok_pkg::MODE_INT, jtok_pkg::MODE_FRAC:
            begin
                if (!digit)
                begin
                    if ((mode_reg == jtok_pkg::MODE_INT) && (ch == jtok_pkg::CH_DOT))
                    begin
                        mode_next = jtok_pkg::MODE_DOT;
                    end
                    else
                    begin
                        rec_ctl[n]   = '{kind: jtok_pkg::KIND_NUMBER, code: jtok_pkg::ERR_NONE};
                        rec_start[n] = tb_reg;
                        rec_len[n]   = pos_reg - tb_reg;
                        n            = n + 2'd1;
                        mode_next    = jtok_pkg::MODE_IDLE;
                        fresh        = 1'b1;
                    end
                end
            end
            jtok_pkg::MODE_DOT:
            begin
                if (digit)
                begin
                    mode_next = jtok_pkg::MODE_FRAC;
                end
                else
                begin
                    // number ends before the dot, the dot itself is the bad byte
                    rec_ctl[n]   = '{kind: jtok_pkg::KIND_NUMBER, code: jtok_pkg::ERR_NONE};
                    rec_start[n] = tb_reg;
                    rec_len[n]   = dot - tb_reg;
                    n            = n + 2'd1;
                    rec_ctl[n]   = '{kind: jtok_pkg::KIND_ERROR, code: jtok_pkg::ERR_BAD_CHAR};
                    rec_start[n] = dot;
                    rec_len[n]   = POS_ONE;
                    n            = n + 2'd1;
                    mode_next    = jtok_pkg::MODE_ERR;
                end
            end
            jtok_pkg::MODE_ERR:
            begin
                mode_next = jtok_pkg::MODE_ERR;
            end
            default:
            begin
                mode_next = jtok_pkg::MODE_ERR;
            end
        endcase

        // Start a new token at this byte.
        if (fresh)
        begin
            tb_next = pos_reg;
            unique case (ch) inside
                jtok_pkg::CH_LBRACE, jtok_pkg::CH_RBRACE, jtok_pkg::CH_LBRACKET,
                jtok_pkg::CH_RBRACKET, jtok_pkg::CH_COLON, jtok_pkg::CH_COMMA:
                begin
                    case (ch)
                        jtok_pkg::CH_LBRACE:   rec_ctl[n].kind = jtok_pkg::KIND_BEGIN_OBJ;
                        jtok_pkg::CH_RBRACE:   rec_ctl[n].kind = jtok_pkg::KIND_END_OBJ;
                        jtok_pkg::CH_LBRACKET: rec_ctl[n].kind = jtok_pkg::KIND_BEGIN_ARR;
                        jtok_pkg::CH_RBRACKET: rec_ctl[n].kind = jtok_pkg::KIND_END_ARR;
                        jtok_pkg::CH_COLON:    rec_ctl[n].kind = jtok_pkg::KIND_COLON;
                        default:               rec_ctl[n].kind = jtok_pkg::KIND_COMMA;
                    endcase
                    rec_ctl[n].code = jtok_pkg::ERR_NONE;
                    rec_start[n]    = pos_reg;
                    rec_len[n]      = POS_ONE;
                    n               = n + 2'd1;
                end
                jtok_pkg::CH_T:
                begin
                    mode_next  = jtok_pkg::MODE_LIT;
                    which_next = jtok_pkg::LIT_TRUE;
                    idx_next   = '0;
                end
                jtok_pkg::CH_F:
                begin
                    mode_next  = jtok_pkg::MODE_LIT;
                    which_next = jtok_pkg::LIT_FALSE;
                    idx_next   = '0;
                end
                jtok_pkg::CH_N:
                begin
                    mode_next  = jtok_pkg::MODE_LIT;
                    which_next = jtok_pkg::LIT_NULL;
                    idx_next   = '0;
                end
                jtok_pkg::CH_SPACE, jtok_pkg::CH_TAB, jtok_pkg::CH_LF, jtok_pkg::CH_CR:
                begin
                    mode_next = jtok_pkg::MODE_IDLE;
                end
                jtok_pkg::CH_QUOTE:
                begin
                    mode_next = jtok_pkg::MODE_STR;
                end
                jtok_pkg::CH_MINUS, [jtok_pkg::CH_0:jtok_pkg::CH_9]:
                begin
                    mode_next = jtok_pkg::MODE_INT;
                end
                default:
                begin
                    rec_ctl[n]   = '{kind: jtok_pkg::KIND_ERROR, code: jtok_pkg::ERR_BAD_CHAR};
                    rec_start[n] = pos_reg;
                    rec_len[n]   = POS_ONE;
                    n            = n + 2'd1;
                    mode_next    = jtok_pkg::MODE_ERR;
                end
            endcase
        end

        pos_next = nxt;

        // Close the document: flush what is pending, then the EOF record unless the document has errored.
        if (last)
        begin
            unique case (mode_next)
                jtok_pkg::MODE_INT, jtok_pkg::MODE_FRAC:
                begin
                    rec_ctl[n]   = '{kind: jtok_pkg::KIND_NUMBER, code: jtok_pkg::ERR_NONE};
                    rec_start[n] = tb_next;
                    rec_len[n]   = nxt - tb_next;
                    n            = n + 2'd1;
                end
                jtok_pkg::MODE_DOT:
                begin
                    rec_ctl[n]   = '{kind: jtok_pkg::KIND_NUMBER, code: jtok_pkg::ERR_NONE};
                    rec_start[n] = tb_next;
                    rec_len[n]   = pos_reg - tb_next;
                    n            = n + 2'd1;
                    rec_ctl[n]   = '{kind: jtok_pkg::KIND_ERROR, code: jtok_pkg::ERR_BAD_CHAR};
                    rec_start[n] = pos_reg;
                    rec_len[n]   = POS_ONE;
                    n            = n + 2'd1;
                    errored      = 1'b1;
                end
                jtok_pkg::MODE_LIT:
                begin
                    rec_ctl[n]   = '{kind: jtok_pkg::KIND_ERROR, code: jtok_pkg::ERR_BAD_LITERAL};
                    rec_start[n] = tb_next;
                    rec_len[n]   = nxt - tb_next;
                    n            = n + 2'd1;
                    errored      = 1'b1;
                end
                jtok_pkg::MODE_STR, jtok_pkg::MODE_ESC, jtok_pkg::MODE_HEX:
                begin
                    rec_ctl[n]   = '{kind: jtok_pkg::KIND_ERROR, code: jtok_pkg::ERR_NO_QUOTE};
                    rec_start[n] = tb_next;
                    rec_len[n]   = nxt - tb_next;
                    n            = n + 2'd1;
                    errored      = 1'b1;
                end
                jtok_pkg::MODE_ERR:
                begin
                    errored = 1'b1;
                end
                default:
                begin
                    errored = 1'b0;
                end
            endcase

            if (!errored)
            begin
                rec_ctl[n]   = '{kind: jtok_pkg::KIND_EOF, code: jtok_pkg::ERR_NONE};
                rec_start[n] = nxt;
                rec_len[n]   = '0;
                n            = n + 2'd1;
            end

            mode_next  = jtok_pkg::MODE_IDLE;
            which_next = jtok_pkg::LIT_TRUE;
            idx_next   = '0;
            hex_next   = '0;
            pos_next   = '0;
            tb_next    = '0;
        end

        rec_cnt = n;
    end

endmodule

`default_nettype wire

// File: hdl/json_tokenizer.sv
// Path: an accepted byte goes through the input register and the scanner into the
//   result register, which drives the token port.
// Throughput: one byte per cycle while the token port is ready and each byte yields at
//   most one record; a byte that yields more records holds the result register until all are taken.
// Reset (rst_n, async, active low): scanner idle between tokens, offset 0,
//   input and result registers empty.
`default_nettype none

module json_tokenizer #(
    parameter int POSITION_BITS = jtok_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    jtok_text_if.sink      text,
    jtok_token_if.source   token
);

    // Input register: one text word waiting for the scanner.
    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Result register: every record one byte produces, drained one per cycle while the token port is ready.
    logic [1:0]                 grp_cnt_reg;
    logic [1:0]                 grp_idx_reg;
    jtok_pkg::rec_ctl_t         grp_ctl_reg   [3];
    logic [POSITION_BITS-1:0]   grp_start_reg [3];
    logic [POSITION_BITS-1:0]   grp_len_reg   [3];

    // Scanner results for the byte in the input register.
    logic [1:0]                 rec_cnt;
    jtok_pkg::rec_ctl_t         rec_ctl   [3];
    logic [POSITION_BITS-1:0]   rec_start [3];
    logic [POSITION_BITS-1:0]   rec_len   [3];

    logic [1:0] grp_left;
    logic       grp_free;
    logic       advance;

    // Records still to deliver; the result register frees up when the last
    // one is taken this cycle.
    assign grp_left = grp_cnt_reg - grp_idx_reg;
    assign grp_free = (grp_left == 2'd0) || ((grp_left == 2'd1) && token.ready);
    assign advance  = in_vld_reg && grp_free;

    // Take a new word whenever the input register is empty or empties this cycle.
    assign text.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_char_reg <= text.text_char;
            in_last_reg <= text.end_of_text;
        end
    end

    jtok_lexer #(
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ch        (in_char_reg),
        .last      (in_last_reg),
        .rec_cnt   (rec_cnt),
        .rec_ctl   (rec_ctl),
        .rec_start (rec_start),
        .rec_len   (rec_len)
    );

    // Load the whole record group at once; step the read index per handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_cnt_reg <= '0;
            grp_idx_reg <= '0;
        end
        else if (advance)
        begin
            grp_cnt_reg <= rec_cnt;
            grp_idx_reg <= '0;
        end
        else if (token.valid && token.ready)
        begin
            grp_idx_reg <= grp_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            grp_ctl_reg   <= rec_ctl;
            grp_start_reg <= rec_start;
            grp_len_reg   <= rec_len;
        end
    end

    // Present the current record; offsets keep their low 32 bits.
    assign token.valid        = (grp_left != 2'd0);
    assign token.token_kind   = grp_ctl_reg[grp_idx_reg].kind;
    assign token.error_code   = grp_ctl_reg[grp_idx_reg].code;
    assign token.token_start  = 32'(grp_start_reg[grp_idx_reg]);
    assign token.token_length = 32'(grp_len_reg[grp_idx_reg]);
    assign token.last_of_run  = (grp_left == 2'd1);

endmodule

`default_nettype wire

// File: hdl/jtok_checker.sv
`default_nettype none

module jtok_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        valid,
    input wire logic        ready,
    input wire logic [3:0]  kind,
    input wire logic [31:0] start,
    input wire logic [31:0] length,
    input wire logic [1:0]  code,
    input wire logic        last
);

    // error records carry a cause, all others carry none
    a_code_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> ((kind == jtok_pkg::KIND_ERROR) == (code != jtok_pkg::ERR_NONE)))
        else $error("error_code does not match token_kind");

    // an EOF record is empty and closes its byte's run
    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (kind == jtok_pkg::KIND_EOF)) |-> ((length == 32'd0) && last))
        else $error("EOF record malformed");

    // punctuation tokens are one byte long
    a_punct_len: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (kind <= jtok_pkg::KIND_COMMA)) |-> (length == 32'd1))
        else $error("punctuation token length not one");

    // a stalled record holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !ready) |=> (valid && $stable({kind, start, length, code, last})))
        else $error("stalled record changed");

endmodule

bind json_tokenizer jtok_checker u_jtok_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid  (token.valid),
    .ready  (token.ready),
    .kind   (token.token_kind),
    .start  (token.token_start),
    .length (token.token_length),
    .code   (token.error_code),
    .last   (token.last_of_run)
);

`default_nettype wire
